// ===== sv/jetp_pkg.sv =====
// Package for the Julia escape-time pixel engine.
// Shared constants, config register codes, gradient codes and types.
// No dependencies.
`default_nettype none
package jetp_pkg;

    localparam int FRACTION_BITS_DEF = 28;
    localparam int MAX_POWER_DEF     = 8;

    localparam int ZW = 64;   // internal fixed point word
    localparam logic [ZW-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // config register indexes
    localparam logic [2:0] CFG_C_REAL    = 3'd0;
    localparam logic [2:0] CFG_C_IMAG    = 3'd1;
    localparam logic [2:0] CFG_ITER_LIM  = 3'd2;
    localparam logic [2:0] CFG_POWER     = 3'd3;
    localparam logic [2:0] CFG_GRADIENT  = 3'd4;

    // gradient modes; everything else is grayscale
    localparam logic [3:0] GRAD_WARM     = 4'd1;
    localparam logic [3:0] GRAD_COOL     = 4'd2;
    localparam logic [3:0] GRAD_GREEN    = 4'd3;
    localparam logic [3:0] GRAD_CUBE_R   = 4'd4;
    localparam logic [3:0] GRAD_CUBE_B   = 4'd5;
    localparam logic [3:0] GRAD_OFFS_R   = 4'd7;
    localparam logic [3:0] GRAD_OFFS_B   = 4'd8;
    localparam logic [3:0] GRAD_RAW      = 4'd9;
    localparam logic [3:0] GRAD_RAW_SWAP = 4'd10;

    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
        logic [15:0]        iteration_limit;
        logic [3:0]         power;
        logic [3:0]         gradient_mode;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_PX,
        ST_PX_W,
        ST_PY,
        ST_PY_W,
        ST_SUM,
        ST_CMP,
        ST_T,
        ST_T_W,
        ST_ZY1,
        ST_ZY2,
        ST_ZX1,
        ST_ZX2
    } t_state;

endpackage
`default_nettype wire

// ===== sv/julia_escape_time_pixel.sv =====
// Julia set escape-time pixel engine, one pixel at a time.
// Each multiply runs on the one shared multiplier. A pixel ends at the escaping test
// or, on reaching the limit, at the limit check instead. busy stays high until the
// result strobe, and start is taken again in the strobe cycle. Sync active-low reset
// loads the defaults.
`default_nettype none
module julia_escape_time_pixel #(
    parameter int FRACTION_BITS = jetp_pkg::FRACTION_BITS_DEF,
    parameter int MAX_POWER     = jetp_pkg::MAX_POWER_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output      logic               o_busy,
    input  wire logic signed [31:0] i_start_real,
    input  wire logic signed [31:0] i_start_imag,
    output      logic               o_valid,
    output      logic [15:0]        o_iteration_count,
    output      logic [15:0]        o_pixel_color,
    input  wire logic               i_cfg_valid,
    output      logic               o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int NW = $clog2(MAX_POWER + 1);
    localparam logic [jetp_pkg::ZW-1:0] ONE = 64'd1 << FRACTION_BITS;

    typedef logic signed [jetp_pkg::ZW-1:0] t_fix;

    jetp_pkg::t_cfg   w_cfg;
    jetp_pkg::t_state r_state, n_state;

    t_fix        r_zx, n_zx;
    t_fix        r_zy, n_zy;
    t_fix        r_px, n_px;
    t_fix        r_py, n_py;
    t_fix        r_acc, n_acc;
    t_fix        r_bound, n_bound;
    logic [NW-1:0] r_n, n_n;
    logic [NW-1:0] r_j, n_j;
    logic [15:0] r_i, n_i;
    logic        r_valid, n_valid;
    logic [15:0] r_count, n_count;
    logic [15:0] r_color, n_color;

    logic        w_mul_start;
    t_fix        w_mul_a, w_mul_b, w_mul_p;
    logic        w_mul_done;
    t_fix        w_add_a, w_add_b, w_add_s;
    logic [NW-1:0] w_n;
    logic        w_last_pow;
    logic        w_escape;
    logic        w_at_limit;

    function automatic t_fix sat_add(input t_fix a, input t_fix b);
        logic signed [jetp_pkg::ZW:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({1'b0, jetp_pkg::SAT_MAX}))
            return t_fix'(jetp_pkg::SAT_MAX);
        else if (s < -$signed({1'b0, jetp_pkg::SAT_MAX}))
            return -t_fix'(jetp_pkg::SAT_MAX);
        else
            return s[63:0];
    endfunction

    // RGB565 from count; channels wrap at 8 bits
    function automatic logic [15:0] colour(input logic [15:0] i, input logic [3:0] mode);
        logic [7:0] c, r, g, b;
        c = i[7:0];
        r = c;
        g = c;
        b = c;
        unique case (mode)
            jetp_pkg::GRAD_WARM:   begin r = 8'(c * 8'd3); g = 8'(c * 8'd2); end
            jetp_pkg::GRAD_COOL:   begin g = 8'(c * 8'd2); b = 8'(c * 8'd3); end
            jetp_pkg::GRAD_GREEN:  g = 8'(c * 8'd2);
            jetp_pkg::GRAD_CUBE_R: begin r = 8'(c * c * c); g = 8'(c * c); end
            jetp_pkg::GRAD_CUBE_B: begin g = 8'(c * c); b = 8'(c * c * c); end
            jetp_pkg::GRAD_OFFS_R: begin r = c + 8'd128; g = c + 8'd64; end
            jetp_pkg::GRAD_OFFS_B: begin g = c + 8'd64; b = c + 8'd128; end
            default: ;
        endcase
        if (mode == jetp_pkg::GRAD_RAW)
            return i;
        else if (mode == jetp_pkg::GRAD_RAW_SWAP)
            return {i[4:0], i[10:5], i[15:11]};
        else
            return {r[7:3], g[7:2], b[7:3]};
    endfunction

    jetp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    jetp_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    assign w_n = (5'(w_cfg.power) > 5'(MAX_POWER)) ? NW'(MAX_POWER) : NW'(w_cfg.power);
    assign w_last_pow = (NW'(r_j + 1'b1) == r_n);
    assign w_escape   = (r_acc > r_bound);
    assign w_at_limit = (r_i == w_cfg.iteration_limit);

    // shared saturating adder and multiplier operand select
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = r_zx;
        w_mul_b     = r_zy;
        w_add_a     = r_px;
        w_add_b     = r_py;
        unique case (r_state)
            jetp_pkg::ST_PX: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_px;
                w_mul_b     = r_zx;
            end
            jetp_pkg::ST_PY: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_py;
                w_mul_b     = r_zy;
            end
            jetp_pkg::ST_T:   w_mul_start = 1'b1;
            jetp_pkg::ST_ZY1: begin w_add_a = r_acc; w_add_b = r_acc; end
            jetp_pkg::ST_ZY2: begin
                w_add_a = r_acc;
                w_add_b = 64'($signed(w_cfg.c_imag));
            end
            jetp_pkg::ST_ZX1: begin w_add_a = r_px; w_add_b = -r_py; end
            jetp_pkg::ST_ZX2: begin
                w_add_a = r_acc;
                w_add_b = 64'($signed(w_cfg.c_real));
            end
            default: ;
        endcase
        w_add_s = sat_add(w_add_a, w_add_b);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jetp_pkg::ST_IDLE:  if (i_start) n_state = jetp_pkg::ST_LIMIT;
            jetp_pkg::ST_LIMIT: begin
                if (w_at_limit)        n_state = jetp_pkg::ST_IDLE;
                else if (r_n > NW'(1)) n_state = jetp_pkg::ST_PX;
                else                   n_state = jetp_pkg::ST_SUM;
            end
            jetp_pkg::ST_PX:    n_state = jetp_pkg::ST_PX_W;
            jetp_pkg::ST_PX_W:  if (w_mul_done) n_state = jetp_pkg::ST_PY;
            jetp_pkg::ST_PY:    n_state = jetp_pkg::ST_PY_W;
            jetp_pkg::ST_PY_W:  if (w_mul_done)
                n_state = w_last_pow ? jetp_pkg::ST_SUM : jetp_pkg::ST_PX;
            jetp_pkg::ST_SUM:   n_state = jetp_pkg::ST_CMP;
            jetp_pkg::ST_CMP:   n_state = w_escape ? jetp_pkg::ST_IDLE : jetp_pkg::ST_T;
            jetp_pkg::ST_T:     n_state = jetp_pkg::ST_T_W;
            jetp_pkg::ST_T_W:   if (w_mul_done) n_state = jetp_pkg::ST_ZY1;
            jetp_pkg::ST_ZY1:   n_state = jetp_pkg::ST_ZY2;
            jetp_pkg::ST_ZY2:   n_state = jetp_pkg::ST_ZX1;
            jetp_pkg::ST_ZX1:   n_state = jetp_pkg::ST_ZX2;
            jetp_pkg::ST_ZX2:   n_state = jetp_pkg::ST_LIMIT;
            default:            n_state = jetp_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_zx    = r_zx;
        n_zy    = r_zy;
        n_px    = r_px;
        n_py    = r_py;
        n_acc   = r_acc;
        n_bound = r_bound;
        n_n     = r_n;
        n_j     = r_j;
        n_i     = r_i;
        n_valid = 1'b0;
        n_count = r_count;
        n_color = r_color;
        unique case (r_state)
            jetp_pkg::ST_IDLE: begin
                n_zx = 64'(i_start_real);
                n_zy = 64'(i_start_imag);
                n_i  = '0;
                n_n  = w_n;
                if (7'(w_n) + 7'(FRACTION_BITS) >= 7'd63)
                    n_bound = t_fix'(jetp_pkg::SAT_MAX);
                else
                    n_bound = t_fix'(64'd1 << (7'(w_n) + 7'(FRACTION_BITS)));
            end
            jetp_pkg::ST_LIMIT: begin
                // first power step is exact: one * z == z
                n_px = (r_n == '0) ? t_fix'(ONE) : r_zx;
                n_py = (r_n == '0) ? t_fix'(ONE) : r_zy;
                n_j  = NW'(1);
                if (w_at_limit) begin
                    n_valid = 1'b1;
                    n_count = r_i;
                    n_color = colour(r_i, w_cfg.gradient_mode);
                end
            end
            jetp_pkg::ST_PX_W: if (w_mul_done) n_px = w_mul_p;
            jetp_pkg::ST_PY_W: if (w_mul_done) begin
                n_py = w_mul_p;
                n_j  = NW'(r_j + 1'b1);
            end
            jetp_pkg::ST_SUM:  n_acc = w_add_s;
            jetp_pkg::ST_CMP:  if (w_escape) begin
                n_valid = 1'b1;
                n_count = r_i;
                n_color = colour(r_i, w_cfg.gradient_mode);
            end
            jetp_pkg::ST_T_W:  if (w_mul_done) n_acc = w_mul_p;
            jetp_pkg::ST_ZY1:  n_acc = w_add_s;
            jetp_pkg::ST_ZY2:  n_zy  = w_add_s;
            jetp_pkg::ST_ZX1:  n_acc = w_add_s;
            jetp_pkg::ST_ZX2: begin
                n_zx = w_add_s;
                n_i  = r_i + 16'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jetp_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zx    <= n_zx;
        r_zy    <= n_zy;
        r_px    <= n_px;
        r_py    <= n_py;
        r_acc   <= n_acc;
        r_bound <= n_bound;
        r_n     <= n_n;
        r_j     <= n_j;
        r_i     <= n_i;
        r_count <= n_count;
        r_color <= n_color;
    end

    assign o_busy            = (r_state != jetp_pkg::ST_IDLE);
    assign o_valid           = r_valid;
    assign o_iteration_count = r_count;
    assign o_pixel_color     = r_color;

endmodule
`default_nettype wire

// ===== sv/jetp_cfg.sv =====
// Configuration register file for the Julia escape-time pixel engine.
// Depends on jetp_pkg (t_cfg, register index codes).
`default_nettype none
module jetp_cfg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output      logic                o_cfg_ready,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    output      jetp_pkg::t_cfg      o_cfg
);

    jetp_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c_real          <= -32'sd214748365;
            r_cfg.c_imag          <= 32'sd41875931;
            r_cfg.iteration_limit <= 16'd64;
            r_cfg.power           <= 4'd2;
            r_cfg.gradient_mode   <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jetp_pkg::CFG_C_REAL:   r_cfg.c_real          <= i_cfg_data;
                jetp_pkg::CFG_C_IMAG:   r_cfg.c_imag          <= i_cfg_data;
                jetp_pkg::CFG_ITER_LIM: r_cfg.iteration_limit <= i_cfg_data[15:0];
                jetp_pkg::CFG_POWER:    r_cfg.power           <= i_cfg_data[3:0];
                jetp_pkg::CFG_GRADIENT: r_cfg.gradient_mode   <= i_cfg_data[3:0];
                default: ;  // unmapped index, word dropped
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/jetp_mul.sv =====
// Shared fixed point multiplier: 64x64 magnitude product from four 32x32
// partial products, scaled by 2^-FRACTION_BITS toward zero, saturated.
// Depends on jetp_pkg (ZW, SAT_MAX).
`default_nettype none
module jetp_mul #(
    parameter int FRACTION_BITS = jetp_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [jetp_pkg::ZW-1:0] i_a,
    input  wire logic signed [jetp_pkg::ZW-1:0] i_b,
    output      logic                         o_done,
    output      logic signed [jetp_pkg::ZW-1:0] o_p
);

    localparam int PW = 2 * jetp_pkg::ZW;

    logic                    r_busy;
    logic                    r_done;
    logic [2:0]              r_step;
    logic [jetp_pkg::ZW-1:0] r_x;
    logic [jetp_pkg::ZW-1:0] r_y;
    logic                    r_neg;
    logic [PW-1:0]           r_pp;
    logic [PW-1:0]           r_acc;
    logic [jetp_pkg::ZW-1:0] r_p;

    logic [31:0]             w_xs;
    logic [31:0]             w_ys;
    logic [63:0]             w_prod;
    logic [PW-1:0]           w_pp;
    logic                    w_sat;
    logic [jetp_pkg::ZW-1:0] w_mag;
    logic [jetp_pkg::ZW-1:0] w_fin;

    // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb begin
        w_xs = r_step[1] ? r_x[63:32] : r_x[31:0];
        w_ys = r_step[0] ? r_y[63:32] : r_y[31:0];
        if (r_step[1] && r_step[0]) begin
            w_xs = r_x[63:32];
            w_ys = r_y[63:32];
        end
        w_prod = 64'(w_xs) * 64'(w_ys);
        case (r_step[1:0])
            2'd0:    w_pp = PW'(w_prod);
            2'd3:    w_pp = PW'(w_prod) << 64;
            default: w_pp = PW'(w_prod) << 32;
        endcase
    end

    always_comb begin
        w_sat = |r_acc[PW-1:FRACTION_BITS+63];
        w_mag = w_sat ? jetp_pkg::SAT_MAX : {1'b0, r_acc[FRACTION_BITS+62:FRACTION_BITS]};
        w_fin = r_neg ? (~w_mag + 64'd1) : w_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_a[63] ? (~i_a + 64'd1) : i_a;
            r_y   <= i_b[63] ? (~i_b + 64'd1) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step < 3'd4) r_pp <= w_pp;
            if (r_step >= 3'd1 && r_step <= 3'd4) r_acc <= r_acc + r_pp;
            if (r_step == 3'd5) r_p <= w_fin;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule
`default_nettype wire

// ===== sv/jetp_checker.sv =====
// Port-level checks for the Julia escape-time pixel engine, bound to the top.
// Depends on julia_escape_time_pixel port names.
`default_nettype none
module jetp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_valid
);

    // a taken word keeps the engine busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after start");

    // result strobe lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // result only follows work in flight
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result without a pixel in flight");

    // engine goes idle exactly when it delivers
    a_idle_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_valid)
        else $error("busy dropped without a result");

endmodule

bind julia_escape_time_pixel jetp_checker u_jetp_checker (.*);
`default_nettype wire

// ===== tb/julia_escape_time_pixel_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for julia_escape_time_pixel: directed table, then random phases.
// Depends on jetp_pkg and the julia_escape_time_pixel RTL.
module julia_escape_time_pixel_test;

    localparam int FRAC    = jetp_pkg::FRACTION_BITS_DEF;
    localparam int PWR_MAX = jetp_pkg::MAX_POWER_DEF;
    localparam logic signed [63:0] Q_MAX  = jetp_pkg::SAT_MAX;
    localparam logic signed [64:0] SUM_HI = {1'b0, jetp_pkg::SAT_MAX};
    localparam logic signed [63:0] Q_ONE  = 64'sd1 <<< FRAC;

    localparam logic [3:0] GRAD_GRAY     = 4'd0;
    localparam logic [3:0] GRAD_NOISE    = 4'd6;
    localparam logic [3:0] GRAD_GRAY_TOP = 4'd15;

    localparam logic signed [31:0] C_RE_RST = -32'sd214748365;
    localparam logic signed [31:0] C_IM_RST = 32'sd41875931;
    localparam logic signed [31:0] Q_TOP    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_BOT    = 32'sh8000_0000;

    localparam int PHASES       = 35;
    localparam int PHASE_PIXELS = 50;
    localparam int QUIET_PHASES = 5;

    typedef struct packed {
        logic [15:0] count;
        logic [15:0] color;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
        logic [15:0]        lim;
        logic [3:0]         pwr;
        logic [3:0]         grad;
        logic signed [31:0] z_re;
        logic signed [31:0] z_im;
        logic               typed;
        logic [15:0]        cnt;
        logic [15:0]        col;
    } t_dir_row;

    // Typed rows: far points escape at once, zero limit gives count 0.
    localparam t_dir_row DIR_ROWS [0:22] = '{
        '{C_RE_RST, C_IM_RST, 16'd64, 4'd2, jetp_pkg::GRAD_WARM, Q_TOP, 32'sd0,
          1'b1, 16'd0, 16'h0000},
        '{C_RE_RST, C_IM_RST, 16'd64, 4'd2, jetp_pkg::GRAD_WARM, Q_BOT, Q_BOT,
          1'b1, 16'd0, 16'h0000},
        '{C_RE_RST, C_IM_RST, 16'd64, 4'd2, jetp_pkg::GRAD_WARM, 32'sd0, Q_TOP,
          1'b1, 16'd0, 16'h0000},
        '{C_RE_RST, C_IM_RST, 16'd64, 4'd2, jetp_pkg::GRAD_WARM, 32'sd0, 32'sd0,
          1'b0, 16'd0, 16'h0000},
        '{C_RE_RST, C_IM_RST, 16'd64, 4'd2, jetp_pkg::GRAD_WARM, 32'sh0400_0000,
          32'shFC00_0000, 1'b0, 16'd0, 16'h0000},
        '{C_RE_RST, C_IM_RST, 16'd64, 4'd2, jetp_pkg::GRAD_WARM, 32'sh1800_0000, 32'sd1,
          1'b0, 16'd0, 16'h0000},
        // power zero: bound is one, everything escapes immediately
        '{C_RE_RST, C_IM_RST, 16'd64, 4'd0, jetp_pkg::GRAD_WARM, 32'sd0, 32'sd0,
          1'b1, 16'd0, 16'h0000},
        '{32'sd0, 32'sd0, 16'd0, 4'd2, jetp_pkg::GRAD_OFFS_R, 32'sd0, 32'sd0,
          1'b1, 16'd0, 16'h8200},
        '{32'sd0, 32'sd0, 16'd0, 4'd2, jetp_pkg::GRAD_OFFS_B, 32'sd0, 32'sd0,
          1'b1, 16'd0, 16'h0210},
        // origin never escapes; count 300 wraps the 8-bit channels
        '{32'sd0, 32'sd0, 16'd300, 4'd1, jetp_pkg::GRAD_WARM,   32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd300, 4'd1, jetp_pkg::GRAD_COOL,   32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd300, 4'd1, jetp_pkg::GRAD_GREEN,  32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd300, 4'd1, jetp_pkg::GRAD_CUBE_R, 32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd300, 4'd1, jetp_pkg::GRAD_CUBE_B, 32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd300, 4'd1, GRAD_NOISE,            32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd300, 4'd1, jetp_pkg::GRAD_OFFS_R, 32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd300, 4'd1, jetp_pkg::GRAD_OFFS_B, 32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        // counts past 2047 reach the top field of the raw gradients
        '{32'sd0, 32'sd0, 16'd3000, 4'd1, jetp_pkg::GRAD_RAW,      32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd3000, 4'd1, jetp_pkg::GRAD_RAW_SWAP, 32'sd0, 32'sd0,
          1'b0, 16'd0, 16'd0},
        '{32'sd0, 32'sd0, 16'd5, 4'd8, GRAD_GRAY, 32'sd0, 32'sd0, 1'b0, 16'd0, 16'd0},
        // power above the max clamps
        '{32'sd0, 32'sd0, 16'd20, 4'd15, GRAD_GRAY, 32'sh1200_0000, 32'shF000_0000,
          1'b0, 16'd0, 16'd0},
        '{Q_TOP, Q_BOT, 16'd10, 4'd2, GRAD_GRAY, 32'sd0, 32'sd0, 1'b0, 16'd0, 16'd0},
        '{Q_BOT, Q_TOP, 16'hFFFF, 4'd2, GRAD_GRAY_TOP, Q_TOP, Q_TOP, 1'b1, 16'd0, 16'h0000}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [31:0] i_start_real;
    logic signed [31:0] i_start_imag;
    logic               o_valid;
    logic [15:0]        o_iteration_count;
    logic [15:0]        o_pixel_color;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    jetp_pkg::t_cfg cfg_now;
    t_pixel         pending_pixels [$];
    int unsigned    n_bad = 0;
    bit             gaps_on;

    julia_escape_time_pixel u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_start_real      (i_start_real),
        .i_start_imag      (i_start_imag),
        .o_valid           (o_valid),
        .o_iteration_count (o_iteration_count),
        .o_pixel_color     (o_pixel_color),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (4) #1_000_000_000;
        $display("julia_escape_time_pixel_test NOT OK");
        $finish;
    end

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > SUM_HI)
            return Q_MAX;
        if (s < -SUM_HI)
            return -Q_MAX;
        return s[63:0];
    endfunction

    // magnitude product, truncate toward zero, saturate, then sign
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [63:0]        ma;
        logic [63:0]        mb;
        logic [127:0]       p;
        logic signed [63:0] m;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        p  = ({64'd0, ma} * {64'd0, mb}) >> FRAC;
        m  = (p > {64'd0, jetp_pkg::SAT_MAX}) ? Q_MAX : p[63:0];
        return (a[63] != b[63]) ? -m : m;
    endfunction

    function automatic logic [15:0] shade(input logic [31:0] i, input logic [3:0] mode);
        logic [31:0] r;
        logic [31:0] g;
        logic [31:0] b;
        case (mode)
            jetp_pkg::GRAD_WARM: begin
                r = i * 3; g = i * 2; b = i;
            end
            jetp_pkg::GRAD_COOL: begin
                r = i; g = i * 2; b = i * 3;
            end
            jetp_pkg::GRAD_GREEN: begin
                r = i; g = i * 2; b = i;
            end
            jetp_pkg::GRAD_CUBE_R: begin
                r = i * i * i; g = i * i; b = i;
            end
            jetp_pkg::GRAD_CUBE_B: begin
                r = i; g = i * i; b = i * i * i;
            end
            jetp_pkg::GRAD_OFFS_R: begin
                r = i + 128; g = i + 64; b = i;
            end
            jetp_pkg::GRAD_OFFS_B: begin
                r = i; g = i + 64; b = i + 128;
            end
            jetp_pkg::GRAD_RAW: begin
                r = ((i >> 11) % 32) << 3; g = ((i >> 5) % 64) << 2; b = (i % 32) << 3;
            end
            jetp_pkg::GRAD_RAW_SWAP: begin
                r = (i % 32) << 3; g = ((i >> 5) % 64) << 2; b = ((i >> 11) % 32) << 3;
            end
            default: begin
                r = i; g = i; b = i;
            end
        endcase
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic t_pixel escape_pixel(input logic signed [31:0] re,
                                            input logic signed [31:0] im);
        logic signed [63:0] zx;
        logic signed [63:0] zy;
        logic signed [63:0] cr;
        logic signed [63:0] ci;
        logic signed [63:0] px;
        logic signed [63:0] py;
        logic signed [63:0] t;
        logic signed [63:0] bound;
        int unsigned        n;
        int unsigned        i;
        t_pixel             p;
        zx = {{32{re[31]}}, re};
        zy = {{32{im[31]}}, im};
        cr = {{32{cfg_now.c_real[31]}}, cfg_now.c_real};
        ci = {{32{cfg_now.c_imag[31]}}, cfg_now.c_imag};
        n  = (cfg_now.power > PWR_MAX) ? PWR_MAX : cfg_now.power;
        bound = (n + FRAC >= 63) ? Q_MAX : (64'sd1 <<< (n + FRAC));
        for (i = 0; i < cfg_now.iteration_limit; i++) begin
            px = Q_ONE;
            py = Q_ONE;
            for (int j = 0; j < n; j++) begin
                px = fx_mul(px, zx);
                py = fx_mul(py, zy);
            end
            if (sat_sum(px, py) > bound)
                break;
            t  = fx_mul(zx, zy);
            zy = sat_sum(sat_sum(t, t), ci);
            zx = sat_sum(sat_sum(px, -py), cr);
        end
        p.count = i[15:0];
        p.color = shade(i, cfg_now.gradient_mode);
        return p;
    endfunction

    // mostly inside the |z| < 2 disc so the loop actually runs
    function automatic logic signed [31:0] rand_point();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
        if (sel < 8)
            return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
        return $urandom;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            jetp_pkg::CFG_C_REAL:   cfg_now.c_real          = val;
            jetp_pkg::CFG_C_IMAG:   cfg_now.c_imag          = val;
            jetp_pkg::CFG_ITER_LIM: cfg_now.iteration_limit = val[15:0];
            jetp_pkg::CFG_POWER:    cfg_now.power           = val[3:0];
            jetp_pkg::CFG_GRADIENT: cfg_now.gradient_mode   = val[3:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic signed [31:0] re, input logic signed [31:0] im,
                              input bit typed, input t_pixel typed_out);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_start_real <= re;
        i_start_imag <= im;
        @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
        pending_pixels.push_back(typed ? typed_out : escape_pixel(re, im));
    endtask

    // block is idle once the last pixel word has come back
    task automatic settle();
        i_start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                n_bad++;
                $display("%0t: unexpected pixel count %0d color %h", $time,
                         o_iteration_count, o_pixel_color);
            end else begin
                want = pending_pixels.pop_front();
                if (o_iteration_count !== want.count) begin
                    n_bad++;
                    $display("%0t: iteration_count expected %0d actual %0d", $time,
                             want.count, o_iteration_count);
                end
                if (o_pixel_color !== want.color) begin
                    n_bad++;
                    $display("%0t: pixel_color expected %h actual %h", $time,
                             want.color, o_pixel_color);
                end
            end
        end
    end

    initial begin
        t_dir_row    row;
        logic [15:0] lim;
        logic [3:0]  pwr;
        gaps_on = 1'b1;
        cfg_now = '{C_RE_RST, C_IM_RST, 16'd64, 4'd2, jetp_pkg::GRAD_WARM};
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_start_real <= '0;
        i_start_imag <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= jetp_pkg::CFG_C_REAL;
        i_cfg_data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[k]) begin
            row = DIR_ROWS[k];
            if (row.c_re != cfg_now.c_real || row.c_im != cfg_now.c_imag ||
                row.lim != cfg_now.iteration_limit || row.pwr != cfg_now.power ||
                row.grad != cfg_now.gradient_mode) begin
                settle();
                if (row.c_re != cfg_now.c_real)
                    cfg_write(jetp_pkg::CFG_C_REAL, row.c_re);
                if (row.c_im != cfg_now.c_imag)
                    cfg_write(jetp_pkg::CFG_C_IMAG, row.c_im);
                if (row.lim != cfg_now.iteration_limit)
                    cfg_write(jetp_pkg::CFG_ITER_LIM, {16'd0, row.lim});
                if (row.pwr != cfg_now.power)
                    cfg_write(jetp_pkg::CFG_POWER, {28'd0, row.pwr});
                if (row.grad != cfg_now.gradient_mode)
                    cfg_write(jetp_pkg::CFG_GRADIENT, {28'd0, row.grad});
            end
            push_pixel(row.z_re, row.z_im, row.typed, {row.cnt, row.col});
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            gaps_on = (ph < PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            settle();
            // occasional deep phase: long counts, but only at cheap powers
            if ($urandom_range(0, 6) == 0) begin
                lim = 16'($urandom_range(25, 300));
                pwr = 4'($urandom_range(1, 2));
            end else begin
                lim = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
                pwr = 4'($urandom_range(0, 15));
            end
            cfg_write(jetp_pkg::CFG_C_REAL, ($urandom_range(0, 2) != 0) ?
                      $signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000 : $urandom);
            cfg_write(jetp_pkg::CFG_C_IMAG, ($urandom_range(0, 2) != 0) ?
                      $signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000 : $urandom);
            cfg_write(jetp_pkg::CFG_ITER_LIM, {16'd0, lim});
            cfg_write(jetp_pkg::CFG_POWER, {28'd0, pwr});
            cfg_write(jetp_pkg::CFG_GRADIENT, $urandom_range(0, 15));
            for (int k = 0; k < PHASE_PIXELS; k++)
                push_pixel(rand_point(), rand_point(), 1'b0, '0);
        end

        settle();
        repeat (16) @(posedge i_clk);
        if (n_bad == 0)
            $display("julia_escape_time_pixel_test OK");
        else
            $display("julia_escape_time_pixel_test NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/jetp_pkg.sv
sv/jetp_cfg.sv
sv/jetp_mul.sv
sv/julia_escape_time_pixel.sv
sv/jetp_checker.sv
tb/julia_escape_time_pixel_test.sv
